@@ src/integer_string_parser_assert.svh @@
// Assertion macros used by the back end of the integer string parser RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef INTEGER_STRING_PARSER_ASSERT_SVH
`define INTEGER_STRING_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ISP_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ISP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/isp_pkg.sv @@
// Package for the integer string parser: item types, the classified
// command type and the parse phase encoding. No dependencies.
`timescale 1ns / 1ps

package isp_pkg;

	localparam int unsigned BASE_W   = 6;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned DIGIT_W  = 6;
	localparam int unsigned VALUE_W  = 64;
	localparam int unsigned OFFSET_W = 12;

	localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
	localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

	typedef struct packed {
		logic              first_char;
		logic [BASE_W-1:0] number_base;
		logic [CHAR_W-1:0] char_code;
	} isp_in_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] parsed_value;
		logic                      digits_found;
		logic [OFFSET_W-1:0]       end_offset;
	} isp_out_t;

	// A character after classification by the front end.
	typedef struct packed {
		logic               first;
		logic [BASE_W-1:0]  base;
		logic               is_digit;
		logic [DIGIT_W-1:0] digit;
		logic               is_blank;
		logic               is_sign;
		logic               is_minus;
		logic               is_zero;
		logic               is_x;
	} isp_cls_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SPACE,
		PH_SIGN,
		PH_ZERO,
		PH_DIGITS,
		PH_HEXX
	} isp_phase_t;

endpackage

@@ src/integer_string_parser.sv @@
// Top level of the integer string parser: front end, command queue, back
// end and result queue. Depends on isp_pkg, isp_front, isp_fifo, isp_back.
`timescale 1ns / 1ps

// Streaming strtoll-style integer parser. Characters arrive one per input
// transfer; the first character of a string carries the radix (0 selects
// automatic detection of hex, octal or decimal, 2 to 36 are fixed). Leading
// blanks are skipped, an optional sign is taken, and a 0x prefix or a leading
// zero is honoured as in the C library. Parsing stops at the first character
// that is not a digit of the base, or at NUL, and that character yields one
// result transfer carrying the signed value (wrapping modulo two to the
// sixty-four), a digit-seen flag and the number of characters consumed. A
// string restarted before it ended is dropped silently, and characters sent
// while no string is open are ignored. The block sustains one character per
// clock cycle while the result queue has room: the rate is set by the back
// end, whose combinational multiply-accumulate (64 by 6 bits) feeds the
// accumulator register, updated once per character. A character accepted
// into the command queue is processed by the back end while the result queue
// has room, and its result is written into the result queue, from which the
// result ports show it until it is taken. Both sides are queues of two
// entries, so either side may stall for a while without holding up the other.
module integer_string_parser
	import isp_pkg::*;
#(
	parameter int unsigned POSITION_BITS = 12
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  isp_in_t  item,
	input  logic     pop,
	output logic     empty,
	output isp_out_t result
);

	localparam int unsigned QUEUE_AW = 1;

	isp_cls_t cmd_wr;
	isp_cls_t cmd_rd;
	logic     cmd_push;
	logic     cmd_full;
	logic     cmd_pop;
	logic     cmd_empty;
	isp_out_t res_wr;
	logic     res_push;
	logic     res_full;

	isp_front u_front (
		.item   (item),
		.push   (push),
		.full   (full),
		.q_full (cmd_full),
		.q_push (cmd_push),
		.q_cmd  (cmd_wr)
	);

	isp_fifo #(
		.item_t (isp_cls_t),
		.AW     (QUEUE_AW)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_wr),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_rd),
		.empty  (cmd_empty)
	);

	isp_back #(
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_rd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_wr)
	);

	isp_fifo #(
		.item_t (isp_out_t),
		.AW     (QUEUE_AW)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wr),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

@@ src/isp_fifo.sv @@
// Small first-word-fall-through queue of registers, any packed item type.
// No package dependencies.
`timescale 1ns / 1ps

module isp_fifo #(
	parameter type         item_t = logic,
	parameter int unsigned AW     = 1
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t wdata,
	output logic  full,
	input  logic  pop,
	output item_t rdata,
	output logic  empty
);

	localparam int unsigned DEPTH = 1 << AW;

	item_t         mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [AW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ src/isp_front.sv @@
// Front end of the integer string parser: takes input transfers and
// classifies each character. Depends on isp_pkg.
`timescale 1ns / 1ps

module isp_front
	import isp_pkg::*;
(
	input  isp_in_t  item,
	input  logic     push,
	output logic     full,
	input  logic     q_full,
	output logic     q_push,
	output isp_cls_t q_cmd
);

	logic [CHAR_W-1:0] c;

	assign c      = item.char_code;
	assign full   = q_full;
	assign q_push = push;

	always_comb begin
		q_cmd          = '0;
		q_cmd.first    = item.first_char;
		q_cmd.base     = item.number_base;
		q_cmd.is_blank = (c == 8'h20) || (c == 8'h09);
		q_cmd.is_sign  = (c == 8'h2B) || (c == 8'h2D);
		q_cmd.is_minus = (c == 8'h2D);
		q_cmd.is_zero  = (c == 8'h30);
		q_cmd.is_x     = (c == 8'h78) || (c == 8'h58);
		// Map '0'-'9', 'a'-'z' and 'A'-'Z' onto digit values 0 to 35.
		if (c >= 8'h30 && c <= 8'h39) begin
			q_cmd.is_digit = 1'b1;
			q_cmd.digit    = DIGIT_W'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			q_cmd.is_digit = 1'b1;
			q_cmd.digit    = DIGIT_W'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			q_cmd.is_digit = 1'b1;
			q_cmd.digit    = DIGIT_W'(c - 8'h37);
		end
	end

endmodule

@@ src/isp_back.sv @@
// Back end of the integer string parser: the parse state machine with its
// accumulator and position counter. Depends on isp_pkg and the assert header.
`timescale 1ns / 1ps
`include "integer_string_parser_assert.svh"

module isp_back
	import isp_pkg::*;
#(
	parameter int unsigned POSITION_BITS = 12
) (
	input  logic     clk,
	input  logic     arst_n,
	input  isp_cls_t cmd,
	input  logic     cmd_empty,
	output logic     cmd_pop,
	input  logic     res_full,
	output logic     res_push,
	output isp_out_t res
);

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	isp_phase_t               phase_q;
	logic [VALUE_W-1:0]       acc_q;
	logic                     neg_q;
	logic                     any_q;
	logic [BASE_W-1:0]        base_q;
	logic [POSITION_BITS-1:0] pos_q;

	isp_phase_t               phase_d;
	logic [VALUE_W-1:0]       acc_d;
	logic                     neg_d;
	logic                     any_d;
	logic [BASE_W-1:0]        base_d;
	logic [POSITION_BITS-1:0] pos_d;

	logic                     emit;
	logic [1:0]               adv;
	logic [POSITION_BITS-1:0] room;
	logic                     done;

	assign cmd_pop  = ~cmd_empty & ~res_full;
	assign res_push = cmd_pop & emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			any_q   <= 1'b0;
			base_q  <= BASE_DEC;
			pos_q   <= '0;
		end else if (cmd_pop) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			any_q   <= any_d;
			base_q  <= base_d;
			pos_q   <= pos_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		any_d   = any_q;
		base_d  = base_q;
		pos_d   = pos_q;
		emit    = 1'b0;
		adv     = 2'd0;
		done    = 1'b0;
		res     = '0;
		room    = '0;

		if (cmd.first) begin
			phase_d = PH_SPACE;
			acc_d   = '0;
			neg_d   = 1'b0;
			any_d   = 1'b0;
			base_d  = cmd.base;
			pos_d   = '0;
		end

		if (phase_d == PH_IDLE) begin
			done = 1'b1;
		end

		if (!done && phase_d == PH_SPACE) begin
			if (cmd.is_blank) begin
				adv  = 2'd1;
				done = 1'b1;
			end else begin
				phase_d = PH_SIGN;
				if (cmd.is_sign) begin
					neg_d = cmd.is_minus;
					adv   = 2'd1;
					done  = 1'b1;
				end
			end
		end

		if (!done && phase_d == PH_SIGN) begin
			if (cmd.is_zero && (base_d == BASE_AUTO || base_d == BASE_HEX)) begin
				adv     = 2'd1;
				any_d   = 1'b1;
				phase_d = PH_ZERO;
				done    = 1'b1;
			end else begin
				if (base_d == BASE_AUTO) begin
					base_d = BASE_DEC;
				end
				phase_d = PH_DIGITS;
			end
		end

		if (!done && phase_d == PH_ZERO) begin
			if (cmd.is_x) begin
				base_d  = BASE_HEX;
				phase_d = PH_HEXX;
				done    = 1'b1;
			end else begin
				if (base_d == BASE_AUTO) begin
					base_d = BASE_OCT;
				end
				phase_d = PH_DIGITS;
			end
		end

		if (!done && phase_d == PH_DIGITS) begin
			done = 1'b1;
			if (cmd.is_digit && cmd.digit < base_d) begin
				acc_d = acc_d * VALUE_W'(base_d) + VALUE_W'(cmd.digit);
				any_d = 1'b1;
				adv   = 2'd1;
			end else begin
				emit             = 1'b1;
				res.parsed_value = neg_d ? -acc_d : acc_d;
				res.digits_found = any_d;
				res.end_offset   = any_d ? OFFSET_W'(pos_d) : '0;
				phase_d          = PH_IDLE;
			end
		end

		if (!done && phase_d == PH_HEXX) begin
			if (cmd.is_digit && cmd.digit < BASE_HEX) begin
				acc_d   = VALUE_W'(cmd.digit);
				any_d   = 1'b1;
				adv     = 2'd2;
				phase_d = PH_DIGITS;
			end else begin
				// A bare "0x" prefix: the zero counts, the 'x' does not.
				emit             = 1'b1;
				res.parsed_value = '0;
				res.digits_found = 1'b1;
				res.end_offset   = OFFSET_W'(pos_d);
				phase_d          = PH_IDLE;
			end
		end

		// Saturating advance of the position counter.
		if (adv != 2'd0) begin
			room = POS_MAX - pos_d;
			if (room < POSITION_BITS'(adv)) begin
				pos_d = POS_MAX;
			end else begin
				pos_d = pos_d + POSITION_BITS'(adv);
			end
		end
	end

	`ISP_ASSERT_NEXT(a_emit_idles, res_push, phase_q == PH_IDLE, "phase not idle after result")
	`ISP_ASSERT_IMPLY(a_nodigit_offset, res_push && !res.digits_found, res.end_offset == '0,
		"offset must be zero when no digit was found")
	`ISP_ASSERT_IMPLY(a_idle_silent, cmd_pop && phase_q == PH_IDLE && !cmd.first, !res_push,
		"result raised for a character outside any string")
	`ISP_ASSERT_IMPLY(a_hexx_base, phase_q == PH_HEXX, base_q == BASE_HEX,
		"hex prefix phase without base sixteen")
	`ISP_ASSERT_NEXT(a_pos_monotonic, cmd_pop && !cmd.first, pos_q >= $past(pos_q),
		"position counter went backwards within a string")

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the streaming integer string parser.
// Depends on isp_pkg and integer_string_parser, and through it on the other RTL files.
`timescale 1ns / 1ps

module testbench;
	import isp_pkg::*;

	// The offset counter width of the instance, and the value at which it sticks.
	localparam int unsigned POS_BITS = 12;
	localparam longint unsigned POS_CEILING = (64'd1 << POS_BITS) - 64'd1;

	// Characters with a meaning of their own to the parser.
	localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
	localparam int unsigned NOT_A_DIGIT = 255;

	// Length of the run and of the pressure episodes.
	localparam int unsigned ITEM_TARGET   = 1500;
	localparam int unsigned LONG_BLANKS   = 40;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned SETTLE_CYCLES = 10;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SHOWN_ERRORS  = 10;

	logic     clk;
	logic     arst_n;
	logic     push = 1'b0;
	logic     full;
	isp_in_t  item = '0;
	logic     pop = 1'b0;
	logic     empty;
	isp_out_t result;

	integer_string_parser #(
		.POSITION_BITS(POS_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.pop(pop),
		.empty(empty),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Characters still to be offered, and the parse results that the block owes us.
	isp_in_t  char_stream[$];
	isp_out_t awaited_numbers[$];

	// Bookkeeping shared between the stimulus builder, driver and monitor.
	int unsigned chars_planned = 0;
	int unsigned chars_accepted = 0;
	int unsigned numbers_checked = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned stage_one_end = 0;
	int unsigned stage_two_end = 0;
	bit          open_pending = 1'b0;
	logic [BASE_W-1:0] open_base = BASE_AUTO;

	// ------------------------------------------------------------------
	// Predictor. It keeps its own copy of the parser state and advances it
	// by one character for every input transfer, exactly as the block must.
	// ------------------------------------------------------------------
	isp_phase_t        pr_phase = PH_IDLE;
	logic [VALUE_W-1:0] pr_acc = '0;
	logic              pr_negative = 1'b0;
	logic              pr_seen_digit = 1'b0;
	logic [BASE_W-1:0] pr_radix = BASE_DEC;
	longint unsigned   pr_consumed = 0;

	function automatic int unsigned char_digit_value(input logic [CHAR_W-1:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return int'(c - CH_ZERO);
		if (c >= "a" && c <= "z")
			return int'(c - "a") + 10;
		if (c >= "A" && c <= "Z")
			return int'(c - "A") + 10;
		return NOT_A_DIGIT;
	endfunction

	// The consumed-character count sticks at its ceiling instead of wrapping.
	function automatic void bump_consumed(input longint unsigned n);
		if (pr_consumed >= POS_CEILING || POS_CEILING - pr_consumed < n)
			pr_consumed = POS_CEILING;
		else
			pr_consumed += n;
	endfunction

	// Returns 1 when this character ends the string, with the result in res.
	function automatic bit predict_parse(input isp_in_t ch, output isp_out_t res);
		logic [CHAR_W-1:0] c;
		int unsigned d;
		bit settled;
		c = ch.char_code;
		res = '0;
		predict_parse = 1'b0;
		if (ch.first_char) begin
			// A new string always starts afresh, dropping whatever was open.
			pr_phase = PH_SPACE;
			pr_acc = '0;
			pr_negative = 1'b0;
			pr_seen_digit = 1'b0;
			pr_radix = ch.number_base;
			pr_consumed = 0;
		end
		settled = 1'b0;
		// Some phases hand the same character on to the next phase, hence the loop.
		while (!settled) begin
			case (pr_phase)
				PH_IDLE: begin
					settled = 1'b1;
				end
				PH_SPACE: begin
					if (c == CH_SPACE || c == CH_TAB) begin
						bump_consumed(1);
						settled = 1'b1;
					end else begin
						pr_phase = PH_SIGN;
						if (c == CH_PLUS || c == CH_MINUS) begin
							pr_negative = (c == CH_MINUS);
							bump_consumed(1);
							settled = 1'b1;
						end
					end
				end
				PH_SIGN: begin
					if (c == CH_ZERO && (pr_radix == BASE_AUTO || pr_radix == BASE_HEX)) begin
						// The zero counts as a digit whether or not an x follows.
						bump_consumed(1);
						pr_seen_digit = 1'b1;
						pr_phase = PH_ZERO;
						settled = 1'b1;
					end else begin
						if (pr_radix == BASE_AUTO)
							pr_radix = BASE_DEC;
						pr_phase = PH_DIGITS;
					end
				end
				PH_ZERO: begin
					if (c == CH_LOWER_X || c == CH_UPPER_X) begin
						// The x is only counted once a hex digit confirms it.
						pr_radix = BASE_HEX;
						pr_phase = PH_HEXX;
						settled = 1'b1;
					end else begin
						if (pr_radix == BASE_AUTO)
							pr_radix = BASE_OCT;
						pr_phase = PH_DIGITS;
					end
				end
				PH_DIGITS: begin
					d = char_digit_value(c);
					if (d < pr_radix) begin
						pr_acc = pr_acc * VALUE_W'(pr_radix) + VALUE_W'(d);
						pr_seen_digit = 1'b1;
						bump_consumed(1);
					end else begin
						res.parsed_value = pr_negative ? -pr_acc : pr_acc;
						res.digits_found = pr_seen_digit;
						res.end_offset = pr_seen_digit ? OFFSET_W'(pr_consumed) : '0;
						pr_phase = PH_IDLE;
						predict_parse = 1'b1;
					end
					settled = 1'b1;
				end
				PH_HEXX: begin
					d = char_digit_value(c);
					if (d < 16) begin
						pr_acc = VALUE_W'(d);
						pr_seen_digit = 1'b1;
						bump_consumed(2);
						pr_phase = PH_DIGITS;
					end else begin
						// A bare 0x parses as the zero alone, ending at the x.
						res.parsed_value = '0;
						res.digits_found = 1'b1;
						res.end_offset = OFFSET_W'(pr_consumed);
						pr_phase = PH_IDLE;
						predict_parse = 1'b1;
					end
					settled = 1'b1;
				end
				default: begin
					pr_phase = PH_IDLE;
					settled = 1'b1;
				end
			endcase
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus building. Characters are queued here and handed out by the
	// driver; the first character after start_string carries the radix.
	// ------------------------------------------------------------------
	task automatic add_char(input logic [CHAR_W-1:0] c);
		isp_in_t ch;
		ch.first_char = open_pending;
		// The radix is ignored on later characters, so it is left random there.
		ch.number_base = open_pending ? open_base : BASE_W'($urandom);
		ch.char_code = c;
		char_stream.push_back(ch);
		open_pending = 1'b0;
		chars_planned++;
	endtask

	task automatic start_string(input logic [BASE_W-1:0] base);
		open_pending = 1'b1;
		open_base = base;
	endtask

	task automatic add_text(input logic [BASE_W-1:0] base, input string s);
		start_string(base);
		foreach (s[i])
			add_char(s[i]);
	endtask

	// A well-formed number with random content. When cut is set the string
	// stops without a terminator, so the next string drops it.
	task automatic add_number(input bit cut);
		logic [BASE_W-1:0] base;
		logic [CHAR_W-1:0] c;
		int unsigned pick, radix_eff, span, count, v, low;
		bit lead_nonzero;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			base = BASE_AUTO;
		else if (pick < 44)
			base = BASE_DEC;
		else if (pick < 57)
			base = BASE_HEX;
		else if (pick < 64)
			base = BASE_OCT;
		else if (pick < 71)
			base = 6'd2;
		else if (pick < 77)
			base = 6'd36;
		else if (pick < 87)
			base = BASE_W'($urandom_range(3, 35));
		else if (pick < 95)
			base = BASE_W'($urandom_range(37, 63));
		else
			base = 6'd1;
		start_string(base);
		repeat ($urandom_range(0, 2))
			add_char($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
		pick = $urandom_range(0, 99);
		if (pick < 20)
			add_char(CH_MINUS);
		else if (pick < 32)
			add_char(CH_PLUS);
		radix_eff = base;
		lead_nonzero = 1'b0;
		pick = $urandom_range(0, 99);
		if ((base == BASE_AUTO || base == BASE_HEX) && pick < 40) begin
			add_char(CH_ZERO);
			add_char($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
			radix_eff = 16;
		end else if (base == BASE_AUTO && pick < 58) begin
			add_char(CH_ZERO);
			radix_eff = 8;
		end else if (base == BASE_AUTO) begin
			// Without a prefix a leading zero would switch to octal.
			radix_eff = 10;
			lead_nonzero = 1'b1;
		end
		span = (radix_eff > 36) ? 36 : radix_eff;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			count = 0;
		else if (pick < 85)
			count = $urandom_range(1, 8);
		else
			count = $urandom_range(9, 30);
		for (int unsigned k = 0; k < count; k++) begin
			low = (lead_nonzero && k == 0) ? 1 : 0;
			v = $urandom_range(low, span - 1);
			if (v < 10)
				c = CH_ZERO + CHAR_W'(v);
			else
				c = ($urandom_range(0, 1) ? "a" : "A") + CHAR_W'(v - 10);
			add_char(c);
		end
		if (!cut) begin
			if ($urandom_range(0, 99) < 45) begin
				add_char(CH_NUL);
			end else begin
				do
					c = CHAR_W'($urandom_range(1, 255));
				while (char_digit_value(c) < radix_eff);
				add_char(c);
			end
			// Now and then a stray character while nothing is open: ignored.
			if ($urandom_range(0, 99) < 4)
				char_stream.push_back('{1'b0, BASE_W'($urandom), CHAR_W'($urandom)});
		end
	endtask

	// Arbitrary bytes with arbitrary string starts sprinkled in.
	task automatic add_noise();
		int unsigned n;
		n = $urandom_range(1, 6);
		for (int unsigned k = 0; k < n; k++) begin
			if (k == 0 || $urandom_range(0, 9) == 0)
				start_string(BASE_W'($urandom));
			add_char(CHAR_W'($urandom));
		end
	endtask

	// ------------------------------------------------------------------
	// Idling. The run falls into three stages by number of characters
	// transferred: sender idles lightly and receiver heavily, then the
	// reverse, then neither idles.
	// ------------------------------------------------------------------
	function automatic int unsigned run_stage();
		if (chars_accepted < stage_one_end)
			return 0;
		if (chars_accepted < stage_two_end)
			return 1;
		return 2;
	endfunction

	function automatic bit sender_rests();
		case (run_stage())
			0: return $urandom_range(0, 99) < 21;
			1: return $urandom_range(0, 99) < 58;
			default: return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_rests();
		case (run_stage())
			0: return $urandom_range(0, 99) < 58;
			1: return $urandom_range(0, 99) < 21;
			default: return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driver. Each accepted character goes through the predictor at the edge
	// where the transfer happens. Once, midway through the second stage, the
	// driver stops offering until every owed result has been popped.
	// ------------------------------------------------------------------
	bit draining = 1'b0;
	bit drained_once = 1'b0;

	always @(posedge clk) begin
		isp_out_t owed;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				if (predict_parse(item, owed))
					awaited_numbers.push_back(owed);
				chars_accepted++;
				if (!drained_once && chars_accepted == (stage_one_end + stage_two_end) / 2) begin
					draining = 1'b1;
					drained_once = 1'b1;
				end
			end
			if (draining && awaited_numbers.size() == 0)
				draining = 1'b0;
			if (push && full) begin
				// The offered character stays on the port until it is taken.
				push <= 1'b1;
			end else if (char_stream.size() != 0 && !draining && !sender_rests()) begin
				push <= 1'b1;
				item <= char_stream.pop_front();
			end else begin
				push <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor. Every result transfer is compared field by field with the
	// oldest owed result. Once, midway through the first stage, the receiver holds
	// off for a long stretch so that both queues fill and full is seen.
	// ------------------------------------------------------------------
	int unsigned hold_left = 0;
	bit          held_once = 1'b0;

	task automatic report_mismatch(input string what, input isp_out_t want, input isp_out_t got);
		mismatches++;
		if (mismatches <= SHOWN_ERRORS)
			$display("%0t: %s: expected value %0d digits %0b offset %0d, got value %0d digits %0b offset %0d",
				$realtime, what, want.parsed_value, want.digits_found, want.end_offset,
				got.parsed_value, got.digits_found, got.end_offset);
	endtask

	always @(posedge clk) begin
		isp_out_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (awaited_numbers.size() == 0) begin
					report_mismatch("result with none owed", '0, result);
				end else begin
					want = awaited_numbers.pop_front();
					numbers_checked++;
					if (result.parsed_value !== want.parsed_value
						|| result.digits_found !== want.digits_found
						|| result.end_offset !== want.end_offset)
						report_mismatch("wrong result", want, result);
				end
			end
			if (!held_once && chars_accepted >= stage_one_end / 2) begin
				held_once = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= !receiver_rests();
			end
		end
	end

	// A hung block must not hang the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results still owed",
				cycle_count, awaited_numbers.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run.
	// ------------------------------------------------------------------
	initial begin
		int unsigned pick;
		int unsigned regular_chars;
		arst_n = 1'b0;

		// Directed strings. A stray character before any string is ignored.
		char_stream.push_back('{1'b0, 6'd63, 8'hFF});
		// Tab, minus sign and hex prefix under automatic radix, ended by NUL.
		add_text(BASE_AUTO, "\t-0x1F");
		add_char(CH_NUL);
		// A hex prefix with no hex digit after it.
		add_text(BASE_AUTO, "0xg");
		// Radix one: only zero is a digit.
		add_text(6'd1, "01");
		// Largest radix field, every letter a digit, ended by the top byte.
		add_text(6'd63, "+Zz");
		add_char(8'hFF);
		// Negative zero.
		add_text(BASE_DEC, "-0");
		add_char(CH_NUL);
		// A binary string dropped by a restart, then an octal one.
		add_text(6'd2, "11");
		add_text(BASE_AUTO, "07 ");

		// Random part: mostly well-formed numbers, some cut short, some noise.
		while (chars_planned < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 74)
				add_number(1'b0);
			else if (pick < 86)
				add_number(1'b1);
			else
				add_noise();
		end
		regular_chars = char_stream.size();
		stage_one_end = regular_chars / 3;
		stage_two_end = 2 * regular_chars / 3;

		// One string with a long run of leading blanks at the end.
		start_string(BASE_DEC);
		for (int unsigned k = 0; k < LONG_BLANKS; k++)
			add_char(k[0] ? CH_TAB : CH_SPACE);
		add_char(CH_MINUS);
		add_char(CH_NINE);
		add_char(CH_NUL);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (char_stream.size() != 0 || push)
			@(posedge clk);
		while (awaited_numbers.size() != 0)
			@(posedge clk);
		// Let any late, unowed result show itself before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d characters in three idling stages and checked %0d parse results.",
			chars_accepted, numbers_checked);
		$display("Radices 0 to 63, signs, prefixes, restarts, a long hold-off, a drain and long blank runs.");
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
